// File: design/smv_pkg.sv
// ----------------------------------------------------------------------------
// smv_pkg
// Shared types and constants for the complex 3x3 matrix times half spinor core.
// ----------------------------------------------------------------------------
package smv_pkg;

  // fixed point format of one complex part
  localparam int FRAC_BITS = 27;
  localparam int PART_W    = 32;
  localparam int WORD_W    = 2 * PART_W;
  localparam int PROD_W    = 2 * PART_W;
  // six products of at most 2^62 each plus the rounding bias
  localparam int ACC_W     = PROD_W + 3;
  localparam int N_TERMS   = 3;
  localparam int N_LANES   = 6;
  localparam int N_MWORDS  = 9;

  // rounding bias, half an lsb of the result
  localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(64'd1 << (FRAC_BITS - 1));

  // operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_APPLY = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [WORD_W-1:0] word_0;
    logic [WORD_W-1:0] word_1;
    logic [WORD_W-1:0] word_2;
    logic [WORD_W-1:0] word_3;
    logic [WORD_W-1:0] word_4;
    logic [WORD_W-1:0] word_5;
    logic [WORD_W-1:0] word_6;
    logic [WORD_W-1:0] word_7;
    logic [WORD_W-1:0] word_8;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] out_0;
    logic [WORD_W-1:0] out_1;
    logic [WORD_W-1:0] out_2;
    logic [WORD_W-1:0] out_3;
    logic [WORD_W-1:0] out_4;
    logic [WORD_W-1:0] out_5;
  } out_item_t;

  // per lane register enables
  typedef struct packed {
    logic mul_en;
    logic sum_en;
  } lane_ctl_t;

  typedef logic [N_TERMS-1:0][WORD_W-1:0] term_vec_t;
  typedef logic signed [ACC_W-1:0] acc_t;

endpackage

// File: design/smv_lane.sv
// ----------------------------------------------------------------------------
// smv_lane
// One complex 3-term dot product: a multiply stage and a sum stage.
// ----------------------------------------------------------------------------
module smv_lane (
  input  logic               clk,
  input  smv_pkg::lane_ctl_t ctl,
  input  logic               adj,
  input  smv_pkg::term_vec_t m_terms,
  input  smv_pkg::term_vec_t v_terms,
  output smv_pkg::acc_t      sum_re,
  output smv_pkg::acc_t      sum_im
);

  logic signed [smv_pkg::PROD_W-1:0] p_rr_r [smv_pkg::N_TERMS];
  logic signed [smv_pkg::PROD_W-1:0] p_ii_r [smv_pkg::N_TERMS];
  logic signed [smv_pkg::PROD_W-1:0] p_ri_r [smv_pkg::N_TERMS];
  logic signed [smv_pkg::PROD_W-1:0] p_ir_r [smv_pkg::N_TERMS];
  logic                              adj_r;
  smv_pkg::acc_t                     re_nxt, im_nxt, re_r, im_r;

  // multiply stage: four partial products per term
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      adj_r <= adj;
      for (int k = 0; k < smv_pkg::N_TERMS; k++) begin
        p_rr_r[k] <= $signed(m_terms[k][smv_pkg::WORD_W-1:smv_pkg::PART_W]) *
                     $signed(v_terms[k][smv_pkg::WORD_W-1:smv_pkg::PART_W]);
        p_ii_r[k] <= $signed(m_terms[k][smv_pkg::PART_W-1:0]) *
                     $signed(v_terms[k][smv_pkg::PART_W-1:0]);
        p_ri_r[k] <= $signed(m_terms[k][smv_pkg::WORD_W-1:smv_pkg::PART_W]) *
                     $signed(v_terms[k][smv_pkg::PART_W-1:0]);
        p_ir_r[k] <= $signed(m_terms[k][smv_pkg::PART_W-1:0]) *
                     $signed(v_terms[k][smv_pkg::WORD_W-1:smv_pkg::PART_W]);
      end
    end
  end

  // sum stage: the conjugate flips the sign of the imaginary matrix terms
  always_comb begin
    re_nxt = '0;
    im_nxt = '0;
    for (int k = 0; k < smv_pkg::N_TERMS; k++) begin
      re_nxt = re_nxt + {{(smv_pkg::ACC_W-smv_pkg::PROD_W){p_rr_r[k][smv_pkg::PROD_W-1]}},
                         p_rr_r[k]};
      im_nxt = im_nxt + {{(smv_pkg::ACC_W-smv_pkg::PROD_W){p_ri_r[k][smv_pkg::PROD_W-1]}},
                         p_ri_r[k]};
      if (adj_r) begin
        re_nxt = re_nxt + {{(smv_pkg::ACC_W-smv_pkg::PROD_W){p_ii_r[k][smv_pkg::PROD_W-1]}},
                           p_ii_r[k]};
        im_nxt = im_nxt - {{(smv_pkg::ACC_W-smv_pkg::PROD_W){p_ir_r[k][smv_pkg::PROD_W-1]}},
                           p_ir_r[k]};
      end else begin
        re_nxt = re_nxt - {{(smv_pkg::ACC_W-smv_pkg::PROD_W){p_ii_r[k][smv_pkg::PROD_W-1]}},
                           p_ii_r[k]};
        im_nxt = im_nxt + {{(smv_pkg::ACC_W-smv_pkg::PROD_W){p_ir_r[k][smv_pkg::PROD_W-1]}},
                           p_ir_r[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sum_en) begin
      re_r <= re_nxt;
      im_r <= im_nxt;
    end
  end

  assign sum_re = re_r;
  assign sum_im = im_r;

endmodule

// File: design/smv_merge.sv
// ----------------------------------------------------------------------------
// smv_merge
// Rounds and saturates the lane sums and packs them into the output register.
// ----------------------------------------------------------------------------
module smv_merge (
  input  logic                clk,
  input  logic                load_en,
  input  smv_pkg::acc_t       lane_re [smv_pkg::N_LANES],
  input  smv_pkg::acc_t       lane_im [smv_pkg::N_LANES],
  output smv_pkg::out_item_t  out_item
);

  // round to nearest (ties up), then clamp to a signed 32-bit part
  function automatic logic [smv_pkg::PART_W-1:0] round_sat(input smv_pkg::acc_t a);
    smv_pkg::acc_t                                  t;
    smv_pkg::acc_t                                  q;
    logic [smv_pkg::ACC_W-smv_pkg::PART_W:0]        hi;
    logic [smv_pkg::PART_W-1:0]                     res;
    t  = a + smv_pkg::RND_BIAS;
    q  = t >>> smv_pkg::FRAC_BITS;
    hi = q[smv_pkg::ACC_W-1:smv_pkg::PART_W-1];
    if (hi == '0 || hi == '1) begin
      res = q[smv_pkg::PART_W-1:0];
    end else if (q[smv_pkg::ACC_W-1]) begin
      res = {1'b1, {(smv_pkg::PART_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(smv_pkg::PART_W-1){1'b1}}};
    end
    return res;
  endfunction

  logic [smv_pkg::WORD_W-1:0] packed_w [smv_pkg::N_LANES];
  smv_pkg::out_item_t         item_r;

  // per lane rounding
  always_comb begin
    for (int l = 0; l < smv_pkg::N_LANES; l++) begin
      packed_w[l] = {round_sat(lane_re[l]), round_sat(lane_im[l])};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_en) begin
      item_r.out_0 <= packed_w[0];
      item_r.out_1 <= packed_w[1];
      item_r.out_2 <= packed_w[2];
      item_r.out_3 <= packed_w[3];
      item_r.out_4 <= packed_w[4];
      item_r.out_5 <= packed_w[5];
    end
  end

  assign out_item = item_r;

endmodule

// File: design/su3_matvec_half_spinor_core.sv
// ----------------------------------------------------------------------------
// su3_matvec_half_spinor_core
// Stored complex 3x3 matrix applied to both halves of a half spinor,
// in signed Q4.27 fixed point, with an optional conjugate transpose.
//
//   channel   ports                              direction  payload
//   in        in_valid / in_ready / in_data      input      smv_pkg::in_item_t
//   out       out_valid / out_ready / out_data   output     smv_pkg::out_item_t
//   cfg       cfg_valid / cfg_ready              input      cfg_adjoint_mode
//
// One transaction per cycle on the input while in_ready is high; a vector item
// passes the multiply stage, the sum stage and the output register, held in the
// six lanes and the merge register. A load item updates the matrix at once and
// yields nothing. Reset clears the matrix to zeros and adjoint_mode to 0.
// Each stage holds only when it is full and the stage after it is stalled,
// so bubbles collapse; cfg_ready is always high.
// ----------------------------------------------------------------------------
module su3_matvec_half_spinor_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  smv_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output smv_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_adjoint_mode
);

  logic [smv_pkg::WORD_W-1:0] matrix_r [smv_pkg::N_MWORDS];
  logic [smv_pkg::WORD_W-1:0] in_word  [smv_pkg::N_MWORDS];
  logic                       adj_r;
  logic                       v1_r, v2_r, v3_r;
  logic                       ready1, ready2, ready3;
  logic                       acc_load, acc_apply;
  smv_pkg::lane_ctl_t         lane_ctl;
  smv_pkg::acc_t              lane_re [smv_pkg::N_LANES];
  smv_pkg::acc_t              lane_im [smv_pkg::N_LANES];

  assign in_word[0] = in_data.word_0;
  assign in_word[1] = in_data.word_1;
  assign in_word[2] = in_data.word_2;
  assign in_word[3] = in_data.word_3;
  assign in_word[4] = in_data.word_4;
  assign in_word[5] = in_data.word_5;
  assign in_word[6] = in_data.word_6;
  assign in_word[7] = in_data.word_7;
  assign in_word[8] = in_data.word_8;

  // stage handshake, each stage moves when empty or when the next one moves
  assign ready3    = !v3_r || out_ready;
  assign ready2    = !v2_r || ready3;
  assign ready1    = !v1_r || ready2;
  assign in_ready  = ready1;
  assign cfg_ready = 1'b1;

  assign acc_load  = in_valid && in_ready && (in_data.operation == smv_pkg::OP_LOAD);
  assign acc_apply = in_valid && in_ready && (in_data.operation == smv_pkg::OP_APPLY);

  assign lane_ctl.mul_en = acc_apply;
  assign lane_ctl.sum_en = v1_r && ready2;

  // matrix store and mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adj_r <= 1'b0;
      for (int i = 0; i < smv_pkg::N_MWORDS; i++) begin
        matrix_r[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        adj_r <= cfg_adjoint_mode;
      end
      if (acc_load) begin
        for (int i = 0; i < smv_pkg::N_MWORDS; i++) begin
          matrix_r[i] <= in_word[i];
        end
      end
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ready1) v1_r <= acc_apply;
      if (ready2) v2_r <= v1_r;
      if (ready3) v3_r <= v2_r;
    end
  end

  // six lanes: vector h, row r
  for (genvar l = 0; l < smv_pkg::N_LANES; l++) begin : g_lane
    localparam int H = l / smv_pkg::N_TERMS;
    localparam int R = l % smv_pkg::N_TERMS;
    smv_pkg::term_vec_t m_sel, v_sel;

    // row of the matrix, or column for the adjoint
    always_comb begin
      for (int k = 0; k < smv_pkg::N_TERMS; k++) begin
        m_sel[k] = adj_r ? matrix_r[k * smv_pkg::N_TERMS + R]
                         : matrix_r[R * smv_pkg::N_TERMS + k];
        v_sel[k] = in_word[H * smv_pkg::N_TERMS + k];
      end
    end

    smv_lane u_lane (
      .clk     (clk),
      .ctl     (lane_ctl),
      .adj     (adj_r),
      .m_terms (m_sel),
      .v_terms (v_sel),
      .sum_re  (lane_re[l]),
      .sum_im  (lane_im[l])
    );
  end

  smv_merge u_merge (
    .clk      (clk),
    .load_en  (v2_r && ready3),
    .lane_re  (lane_re),
    .lane_im  (lane_im),
    .out_item (out_data)
  );

  assign out_valid = v3_r;

  // a load transaction never enters the datapath
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc_load |=> !v1_r)
    else $error("load transaction entered the multiply stage");

  // a vector transaction always fills the multiply stage
  a_apply_enters: assert property (@(posedge clk) disable iff (!rst_n)
    acc_apply |=> v1_r)
    else $error("vector transaction lost at the multiply stage");

  // with every stage full and the output stalled, input must stall
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && !out_ready) |-> !in_ready)
    else $error("input accepted while pipeline is full and stalled");

  // a stalled output stage keeps the stage behind it held
  a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && v3_r && !out_ready) |=> v2_r)
    else $error("sum stage dropped a transaction during a stall");

  // a configuration write takes effect on the next cycle
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> (adj_r == $past(cfg_adjoint_mode)))
    else $error("adjoint_mode not updated by configuration write");

endmodule

// File: sim/su3_matvec_half_spinor_core_test.sv
// ----------------------------------------------------------------------------
// su3_matvec_half_spinor_core_test
// Self-checking bench for the complex 3x3 matrix times half spinor core.
// Streams matrix loads and vector transactions through the valid/ready
// channels, with random gaps and back-pressure on both sides. A class keeps
// its own copy of the stored matrix and of adjoint_mode, works out the two
// rounded and saturated complex products of every vector transaction, and
// compares each result field by field, in order. The adjoint setting is
// changed only while the core is drained.
// ----------------------------------------------------------------------------
module su3_matvec_half_spinor_core_test;
  import smv_pkg::*;

  localparam int          DRAIN_CYCLES = 8;
  localparam int          STALL_LIMIT  = 4000;
  localparam int          PHASE_ITEMS  = 160;
  localparam logic [31:0] PART_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] PART_MIN     = 32'h8000_0000;
  localparam logic [31:0] PART_ONE     = 32'h0800_0000;
  // 0.5 in Q4.27; times a one-lsb entry it is half an lsb of the result, for rounding ties
  localparam logic [31:0] PART_HALF    = 32'h0400_0000;

  // expected products of the core, tracked from accepted transactions
  class half_spinor_checker;
    logic [WORD_W-1:0] matrix [N_MWORDS];
    bit                adjoint;
    out_item_t         expected_products_q [$];
    int                n_errors;

    function new();
      for (int i = 0; i < N_MWORDS; i++) matrix[i] = '0;
      adjoint  = 1'b0;
      n_errors = 0;
    endfunction

    // round to nearest, ties up, then clamp to one 32-bit part
    function logic [PART_W-1:0] round_saturate(logic signed [127:0] sum);
      logic signed [127:0] q;
      q = (sum + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (q > 128'sh7FFF_FFFF) return PART_MAX;
      if (q < -(128'sd2147483648)) return PART_MIN;
      return q[PART_W-1:0];
    endfunction

    // one row of M*v or conj(M)^T*v
    function logic [WORD_W-1:0] row_product(int r, logic [WORD_W-1:0] c0,
                                            logic [WORD_W-1:0] c1,
                                            logic [WORD_W-1:0] c2);
      logic signed [127:0] acc_re, acc_im, ar, ai, br, bi;
      logic [WORD_W-1:0]   m, c;
      acc_re = '0;
      acc_im = '0;
      for (int k = 0; k < N_TERMS; k++) begin
        m = adjoint ? matrix[k * 3 + r] : matrix[r * 3 + k];
        c = (k == 0) ? c0 : ((k == 1) ? c1 : c2);
        ar = $signed(m[63:32]);
        ai = $signed(m[31:0]);
        br = $signed(c[63:32]);
        bi = $signed(c[31:0]);
        if (adjoint) begin
          acc_re = acc_re + ar * br + ai * bi;
          acc_im = acc_im + ar * bi - ai * br;
        end else begin
          acc_re = acc_re + ar * br - ai * bi;
          acc_im = acc_im + ar * bi + ai * br;
        end
      end
      return {round_saturate(acc_re), round_saturate(acc_im)};
    endfunction

    // accepted input: store the matrix or queue the expected products
    function void accept_item(in_item_t it);
      out_item_t p;
      if (it.operation == OP_LOAD) begin
        matrix[0] = it.word_0; matrix[1] = it.word_1; matrix[2] = it.word_2;
        matrix[3] = it.word_3; matrix[4] = it.word_4; matrix[5] = it.word_5;
        matrix[6] = it.word_6; matrix[7] = it.word_7; matrix[8] = it.word_8;
      end else begin
        p.out_0 = row_product(0, it.word_0, it.word_1, it.word_2);
        p.out_1 = row_product(1, it.word_0, it.word_1, it.word_2);
        p.out_2 = row_product(2, it.word_0, it.word_1, it.word_2);
        p.out_3 = row_product(0, it.word_3, it.word_4, it.word_5);
        p.out_4 = row_product(1, it.word_3, it.word_4, it.word_5);
        p.out_5 = row_product(2, it.word_3, it.word_4, it.word_5);
        expected_products_q.push_back(p);
      end
    endfunction

    function void compare_word(string name, logic [WORD_W-1:0] exp_w,
                               logic [WORD_W-1:0] act_w);
      if (act_w !== exp_w) begin
        $error("%s: expected %h, actual %h", name, exp_w, act_w);
        n_errors++;
      end
    endfunction

    // accepted result: compare against the oldest expectation
    function void check_products(out_item_t got);
      out_item_t exp_p;
      if (expected_products_q.size() == 0) begin
        $error("unexpected result transaction %h", got);
        n_errors++;
        return;
      end
      exp_p = expected_products_q.pop_front();
      compare_word("out_0", exp_p.out_0, got.out_0);
      compare_word("out_1", exp_p.out_1, got.out_1);
      compare_word("out_2", exp_p.out_2, got.out_2);
      compare_word("out_3", exp_p.out_3, got.out_3);
      compare_word("out_4", exp_p.out_4, got.out_4);
      compare_word("out_5", exp_p.out_5, got.out_5);
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_adjoint_mode;

  half_spinor_checker checker_h = new();
  bit  no_idle;
  int  rx_hold_left;
  int  quiet_cycles;

  su3_matvec_half_spinor_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_adjoint_mode (cfg_adjoint_mode)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side: check accepted transactions, then pick the next ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) checker_h.check_products(out_data);
    if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_ready    <= 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= 31);
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // one part: extremes, small Q4.27 values or anything
  function automatic logic [PART_W-1:0] rand_part();
    case ($urandom_range(7))
      0:       return PART_MIN;
      1:       return PART_MAX;
      2:       return '0;
      3, 4:    return 32'($urandom_range(32'h2000_0000)) - 32'h1000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    return {rand_part(), rand_part()};
  endfunction

  function automatic in_item_t uniform_item(logic op, logic [WORD_W-1:0] w);
    in_item_t it;
    it.operation = op;
    it.word_0 = w; it.word_1 = w; it.word_2 = w;
    it.word_3 = w; it.word_4 = w; it.word_5 = w;
    it.word_6 = w; it.word_7 = w; it.word_8 = w;
    return it;
  endfunction

  function automatic in_item_t random_item(logic op);
    in_item_t it;
    it.operation = op;
    it.word_0 = rand_word(); it.word_1 = rand_word(); it.word_2 = rand_word();
    it.word_3 = rand_word(); it.word_4 = rand_word(); it.word_5 = rand_word();
    it.word_6 = rand_word(); it.word_7 = rand_word(); it.word_8 = rand_word();
    return it;
  endfunction

  // offer one transaction, with a random gap first, and wait for acceptance
  task automatic send_item(in_item_t it);
    while (!no_idle && ($urandom_range(99) < 31)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    checker_h.accept_item(it);
  endtask

  // stop offering and wait until every expected result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (checker_h.expected_products_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(logic mode);
    cfg_valid        <= 1'b1;
    cfg_adjoint_mode <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    checker_h.adjoint = mode;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // rounding ties and saturation corners for the current mode
  task automatic send_corner_items();
    in_item_t it;
    // single small entry, vector on the half-lsb boundary
    it = uniform_item(OP_LOAD, '0);
    it.word_0 = {32'd1, 32'd0};
    send_item(it);
    it = uniform_item(OP_APPLY, '0);
    it.word_0 = {PART_HALF, -PART_HALF};
    it.word_3 = {-PART_HALF, PART_HALF};
    send_item(it);
    // most negative everywhere: products overflow both ways
    send_item(uniform_item(OP_LOAD, {PART_MIN, PART_MIN}));
    send_item(uniform_item(OP_APPLY, {PART_MIN, PART_MIN}));
    send_item(uniform_item(OP_APPLY, {PART_MAX, PART_MAX}));
    send_item(uniform_item(OP_LOAD, {PART_MAX, PART_MIN}));
    send_item(uniform_item(OP_APPLY, {PART_MAX, PART_MAX}));
    send_item(uniform_item(OP_APPLY, {PART_MIN, PART_MAX}));
    send_item(random_item(OP_LOAD));
    send_item(random_item(OP_APPLY));
  endtask

  // random phase: mostly vectors against a matrix reloaded now and then
  task automatic run_phase(int n_items);
    for (int i = 0; i < n_items; i++)
      send_item(random_item(($urandom_range(99) < 20) ? OP_LOAD : OP_APPLY));
  endtask

  initial begin
    in_item_t it;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_data          = '0;
    out_ready        = 1'b0;
    cfg_valid        = 1'b0;
    cfg_adjoint_mode = 1'b0;
    no_idle          = 1'b0;
    rx_hold_left     = 0;
    quiet_cycles     = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, plain mode
    write_mode(1'b0);
    // vectors before any load see the zero matrix
    send_item(random_item(OP_APPLY));
    send_item(uniform_item(OP_APPLY, '1));
    // identity passes the vector through
    it = uniform_item(OP_LOAD, '0);
    it.word_0 = {PART_ONE, 32'd0};
    it.word_4 = {PART_ONE, 32'd0};
    it.word_8 = {PART_ONE, 32'd0};
    send_item(it);
    send_item(uniform_item(OP_APPLY, {PART_MAX, PART_MIN}));
    send_item(random_item(OP_APPLY));
    send_corner_items();
    drain();

    // directed, adjoint mode
    write_mode(1'b1);
    send_corner_items();
    drain();

    // random, adjoint mode, with a long receiver hold-off at the start
    rx_hold_left = 100;
    run_phase(PHASE_ITEMS);
    drain();

    // random, plain mode, first part with no gaps on either side
    write_mode(1'b0);
    no_idle = 1'b1;
    run_phase(120);
    no_idle = 1'b0;
    run_phase(PHASE_ITEMS - 120);
    drain();

    write_mode(1'b1);
    run_phase(PHASE_ITEMS);
    drain();

    write_mode(1'($urandom_range(1)));
    run_phase(PHASE_ITEMS);
    drain();

    if (checker_h.n_errors == 0 && checker_h.expected_products_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: su3_matvec_half_spinor_core.f
design/smv_pkg.sv
design/smv_lane.sv
design/smv_merge.sv
design/su3_matvec_half_spinor_core.sv
sim/su3_matvec_half_spinor_core_test.sv
